FILE: design/cpf_pkg.sv
package cpf_pkg;

  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_COLUMNS = 256;

  localparam int PIXEL_W  = 8;
  localparam int SUM_W    = 14;
  localparam int SQ_W     = 22;
  localparam int ALPHA_W  = 17;
  localparam int HEIGHT_W = 7;
  localparam int COL_W    = 8;
  localparam int GPF_W    = 16;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int SPREAD_W = 28;
  localparam int NUM_W    = 44;
  localparam int DEN_W    = 28;
  localparam int HH_W     = 13;
  localparam int H255_W   = 14;
  localparam int T1_W     = 31;

  localparam logic [ALPHA_W-1:0]  ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 17'd32768;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = 7'(MAX_HEIGHT);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = 7'd1;
  localparam logic [MUL_B_W-1:0]  GREY_FULL   = 17'd255;
  // 256 * 255: the fixed part of the denominator.
  localparam logic [MUL_B_W-1:0]  DEN_SCALE   = 17'd65280;
  localparam logic [GPF_W-1:0]    GPF_SAT     = 16'hFFFF;

  // Register address decode: one bit selects between the two registers.
  localparam logic REG_ALPHA  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               column_end;
    logic               frame_end;
  } in_t;

  typedef struct packed {
    logic [GPF_W-1:0] projection_value;
    logic [COL_W-1:0] column_index;
    logic [GPF_W-1:0] running_maximum;
    logic             frame_last;
  } out_t;

endpackage

FILE: design/cpf_mul.sv
module cpf_mul (
  input  logic                         clk,
  input  logic [cpf_pkg::MUL_A_W-1:0]  op_a,
  input  logic [cpf_pkg::MUL_B_W-1:0]  op_b,
  output logic [cpf_pkg::PROD_W-1:0]   prod_r
);

  logic [cpf_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = cpf_pkg::PROD_W'(op_a) * cpf_pkg::PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: design/column_projection_function.sv
// Column projection function: pixels arrive one item at a time, column by column, and
// each column end (or frame end) yields one result holding the column's blended mean
// and variance in Q8.8, its index and the frame's running maximum. All multiplications
// run through one registered 31x17 multiplier under a sequencer, followed by a 16-step
// restoring divider. A pixel that does not end a column passes through accept, square
// and accumulate; a column-end pixel goes on through the sequence and the divider (skipped
// on saturation), then waits while the result register holds a result not yet taken.
// Input is refused while an item is in progress, but a finished result may wait in the
// output register while the next column's pixels are taken.
module column_projection_function (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpf_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cpf_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACC, S_QH, S_SS, S_T1, S_H255, S_T2, S_T3,
    S_HH, S_DEN, S_CHK, S_DIV, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [cpf_pkg::ALPHA_W-1:0]  alpha_r, alpha_nxt;
  logic [cpf_pkg::HEIGHT_W-1:0] height_r, height_nxt;
  logic [cpf_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [cpf_pkg::SQ_W-1:0]     sq_r, sq_nxt;
  logic [cpf_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [cpf_pkg::GPF_W-1:0]    max_r, max_nxt;
  logic                         out_valid_r, out_valid_nxt;
  cpf_pkg::out_t                out_r, out_nxt;

  logic [cpf_pkg::PIXEL_W-1:0]  pix_r, pix_nxt;
  logic                         fend_r, fend_nxt;
  logic                         cend_r, cend_nxt;
  logic [cpf_pkg::SPREAD_W-1:0] qh_r, qh_nxt;
  logic [cpf_pkg::SPREAD_W-1:0] spread_r, spread_nxt;
  logic [cpf_pkg::T1_W-1:0]     t1_r, t1_nxt;
  logic [cpf_pkg::NUM_W-1:0]    num_r, num_nxt;
  logic [cpf_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [cpf_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic                         sat_r, sat_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;

  logic [cpf_pkg::MUL_A_W-1:0]  op_a;
  logic [cpf_pkg::MUL_B_W-1:0]  op_b;
  logic [cpf_pkg::PROD_W-1:0]   prod_r;

  logic [cpf_pkg::ALPHA_W-1:0]  alpha_eff;
  logic [cpf_pkg::ALPHA_W-1:0]  alpha_inv;
  logic [cpf_pkg::HEIGHT_W-1:0] h_eff;
  logic [cpf_pkg::DEN_W:0]      rem2;
  logic                         rem_ge;
  logic [cpf_pkg::GPF_W-1:0]    gpf;
  logic [cpf_pkg::COL_W:0]      col_inc;
  logic                         cfg_wr;

  cpf_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign alpha_eff = (alpha_r > cpf_pkg::ALPHA_ONE) ? cpf_pkg::ALPHA_ONE : alpha_r;
  assign alpha_inv = cpf_pkg::ALPHA_ONE - alpha_eff;
  assign h_eff = (height_r == '0) ? cpf_pkg::HEIGHT_MIN :
                 (height_r > cpf_pkg::HEIGHT_MAX) ? cpf_pkg::HEIGHT_MAX : height_r;

  assign rem2   = {rem_r, num_r[cpf_pkg::GPF_W-1]};
  assign rem_ge = rem2 >= {1'b0, den_r};
  assign gpf    = sat_r ? cpf_pkg::GPF_SAT : num_r[cpf_pkg::GPF_W-1:0];
  assign col_inc = {1'b0, col_r} + 1'b1;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == cpf_pkg::REG_HEIGHT) ? 32'(height_r) : 32'(alpha_r);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Operands for the shared multiplier; its product is read in the next state.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_SQ: begin
        op_a = cpf_pkg::MUL_A_W'(pix_r);
        op_b = cpf_pkg::MUL_B_W'(pix_r);
      end
      S_QH: begin
        op_a = cpf_pkg::MUL_A_W'(sq_r);
        op_b = cpf_pkg::MUL_B_W'(h_eff);
      end
      S_SS: begin
        op_a = cpf_pkg::MUL_A_W'(sum_r);
        op_b = cpf_pkg::MUL_B_W'(sum_r);
      end
      S_T1: begin
        op_a = cpf_pkg::MUL_A_W'(sum_r);
        op_b = alpha_inv;
      end
      S_H255: begin
        op_a = cpf_pkg::MUL_A_W'(h_eff);
        op_b = cpf_pkg::GREY_FULL;
      end
      S_T2: begin
        op_a = t1_r;
        op_b = cpf_pkg::MUL_B_W'(prod_r[cpf_pkg::H255_W-1:0]);
      end
      S_T3: begin
        op_a = cpf_pkg::MUL_A_W'(spread_r);
        op_b = alpha_eff;
      end
      S_HH: begin
        op_a = cpf_pkg::MUL_A_W'(h_eff);
        op_b = cpf_pkg::MUL_B_W'(h_eff);
      end
      S_DEN: begin
        op_a = cpf_pkg::MUL_A_W'(prod_r[cpf_pkg::HH_W-1:0]);
        op_b = cpf_pkg::DEN_SCALE;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    alpha_nxt     = alpha_r;
    height_nxt    = height_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    col_nxt       = col_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pix_nxt       = pix_r;
    fend_nxt      = fend_r;
    cend_nxt      = cend_r;
    qh_nxt        = qh_r;
    spread_nxt    = spread_r;
    t1_nxt        = t1_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    sat_nxt       = sat_r;
    cnt_nxt       = cnt_r;

    if (cfg_wr) begin
      if (paddr[2] == cpf_pkg::REG_HEIGHT) begin
        height_nxt = pwdata[cpf_pkg::HEIGHT_W-1:0];
      end else begin
        alpha_nxt = pwdata[cpf_pkg::ALPHA_W-1:0];
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pix_nxt   = in_data.pixel;
          cend_nxt  = in_data.column_end;
          fend_nxt  = in_data.frame_end;
          sum_nxt   = sum_r + cpf_pkg::SUM_W'(in_data.pixel);
          state_nxt = S_SQ;
        end
      end
      S_SQ: state_nxt = S_ACC;
      S_ACC: begin
        sq_nxt    = sq_r + prod_r[cpf_pkg::SQ_W-1:0];
        state_nxt = (cend_r || fend_r) ? S_QH : S_IDLE;
      end
      S_QH: state_nxt = S_SS;
      S_SS: begin
        qh_nxt    = prod_r[cpf_pkg::SPREAD_W-1:0];
        state_nxt = S_T1;
      end
      S_T1: begin
        // A negative spread (wrapped sums) counts as zero.
        spread_nxt = (qh_r >= prod_r[cpf_pkg::SPREAD_W-1:0]) ?
                     qh_r - prod_r[cpf_pkg::SPREAD_W-1:0] : '0;
        state_nxt  = S_H255;
      end
      S_H255: begin
        t1_nxt    = prod_r[cpf_pkg::T1_W-1:0];
        state_nxt = S_T2;
      end
      S_T2: state_nxt = S_T3;
      S_T3: begin
        num_nxt   = prod_r[cpf_pkg::NUM_W-1:0];
        state_nxt = S_HH;
      end
      S_HH: begin
        num_nxt   = num_r + prod_r[cpf_pkg::NUM_W-1:0];
        state_nxt = S_DEN;
      end
      S_DEN: state_nxt = S_CHK;
      S_CHK: begin
        // A quotient of 2^16 or more saturates, so the divider never runs for it.
        den_nxt   = prod_r[cpf_pkg::DEN_W-1:0];
        sat_nxt   = num_r >= {prod_r[cpf_pkg::DEN_W-1:0], {cpf_pkg::GPF_W{1'b0}}};
        rem_nxt   = num_r[cpf_pkg::NUM_W-1:cpf_pkg::GPF_W];
        cnt_nxt   = '1;
        state_nxt = sat_nxt ? S_FIN : S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_ge ? cpf_pkg::DEN_W'(rem2 - {1'b0, den_r}) :
                           rem2[cpf_pkg::DEN_W-1:0];
        num_nxt[cpf_pkg::GPF_W-1:0] = {num_r[cpf_pkg::GPF_W-2:0], rem_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_nxt.projection_value = gpf;
          out_nxt.column_index     = col_r;
          out_nxt.running_maximum  = (gpf > max_r) ? gpf : max_r;
          out_nxt.frame_last       = fend_r;
          sum_nxt = '0;
          sq_nxt  = '0;
          if (fend_r) begin
            col_nxt = '0;
            max_nxt = '0;
          end else begin
            max_nxt = (gpf > max_r) ? gpf : max_r;
            col_nxt = (col_inc >= (cpf_pkg::COL_W+1)'(cpf_pkg::MAX_COLUMNS)) ?
                      '0 : col_inc[cpf_pkg::COL_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= cpf_pkg::ALPHA_RESET;
      height_r    <= cpf_pkg::HEIGHT_RESET;
      sum_r       <= '0;
      sq_r        <= '0;
      col_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alpha_r     <= alpha_nxt;
      height_r    <= height_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      col_r       <= col_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    pix_r    <= pix_nxt;
    fend_r   <= fend_nxt;
    cend_r   <= cend_nxt;
    qh_r     <= qh_nxt;
    spread_r <= spread_nxt;
    t1_r     <= t1_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    sat_r    <= sat_nxt;
    cnt_r    <= cnt_nxt;
  end

  // An accepted item always keeps the block busy for at least the squaring step.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  // The reported maximum never falls below the column's own value.
  a_max_covers_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.running_maximum >= out_data.projection_value))
    else $error("running maximum below projection value");

  // A new result is loaded only when the previous one has gone or is going.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && state_r == S_FIN) |=> (state_r == S_FIN))
    else $error("result register overwritten while held");

endmodule

FILE: tb/column_projection_function_test.sv
module column_projection_function_test;

  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET   = 1100;
  localparam int PHASE_ITEMS   = 100;
  localparam int LONG_FRAME    = 300;

  typedef enum int {NOISE, BRIGHT, DARK, BAND, STARK} pattern_t;

  class column_scoreboard_t;
    logic [cpf_pkg::ALPHA_W-1:0]  alpha;
    logic [cpf_pkg::HEIGHT_W-1:0] height;
    logic [cpf_pkg::SUM_W-1:0]    pixel_total;
    logic [cpf_pkg::SQ_W-1:0]     square_total;
    logic [cpf_pkg::COL_W-1:0]    column;
    logic [cpf_pkg::GPF_W-1:0]    frame_peak;
    cpf_pkg::out_t                expected_columns[$];
    int                           mismatches;
    int                           results_checked;

    function new();
      alpha = cpf_pkg::ALPHA_RESET;
      height = cpf_pkg::HEIGHT_RESET;
      pixel_total = '0;
      square_total = '0;
      column = '0;
      frame_peak = '0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_register(logic reg_sel, logic [31:0] value);
      if (reg_sel == cpf_pkg::REG_ALPHA) begin
        alpha = value[cpf_pkg::ALPHA_W-1:0];
      end else begin
        height = value[cpf_pkg::HEIGHT_W-1:0];
      end
    endfunction

    // Exact rational blend of mean and variance, truncated to Q8.8.
    function logic [cpf_pkg::GPF_W-1:0] projection_of(logic [cpf_pkg::SUM_W-1:0] s,
                                                      logic [cpf_pkg::SQ_W-1:0] q);
      longint unsigned a, h, ss, qq, spread, num, den, r;
      a = alpha;
      if (a > cpf_pkg::ALPHA_ONE) a = cpf_pkg::ALPHA_ONE;
      h = height;
      if (h == 0) h = 1;
      if (h > cpf_pkg::MAX_HEIGHT) h = cpf_pkg::MAX_HEIGHT;
      ss = s;
      qq = q;
      spread = (qq * h >= ss * ss) ? qq * h - ss * ss : 0;
      num = (cpf_pkg::ALPHA_ONE - a) * ss * cpf_pkg::GREY_FULL * h + a * spread;
      den = cpf_pkg::DEN_SCALE * h * h;
      r = num / den;
      return (r > cpf_pkg::GPF_SAT) ? cpf_pkg::GPF_SAT : r[cpf_pkg::GPF_W-1:0];
    endfunction

    function void note_pixel(cpf_pkg::in_t item);
      cpf_pkg::out_t want;
      int next;
      pixel_total = pixel_total + cpf_pkg::SUM_W'(item.pixel);
      square_total = square_total + cpf_pkg::SQ_W'(item.pixel) * cpf_pkg::SQ_W'(item.pixel);
      if (item.column_end || item.frame_end) begin
        want.projection_value = projection_of(pixel_total, square_total);
        if (want.projection_value > frame_peak) frame_peak = want.projection_value;
        want.column_index = column;
        want.running_maximum = frame_peak;
        want.frame_last = item.frame_end;
        expected_columns.push_back(want);
        pixel_total = '0;
        square_total = '0;
        if (item.frame_end) begin
          column = '0;
          frame_peak = '0;
        end else begin
          next = int'(column) + 1;
          if (next >= cpf_pkg::MAX_COLUMNS) next = 0;
          column = cpf_pkg::COL_W'(next);
        end
      end
    endfunction

    task check_result(cpf_pkg::out_t got);
      cpf_pkg::out_t want;
      results_checked++;
      if (expected_columns.size() == 0) begin
        report($sformatf("column result %h arrived with nothing outstanding", got));
        return;
      end
      want = expected_columns.pop_front();
      if (got.projection_value != want.projection_value)
        report($sformatf("column %0d: projection_value %0d, predicted %0d",
                         want.column_index, got.projection_value, want.projection_value));
      if (got.column_index != want.column_index)
        report($sformatf("column_index %0d, predicted %0d",
                         got.column_index, want.column_index));
      if (got.running_maximum != want.running_maximum)
        report($sformatf("column %0d: running_maximum %0d, predicted %0d",
                         want.column_index, got.running_maximum, want.running_maximum));
      if (got.frame_last != want.frame_last)
        report($sformatf("column %0d: frame_last %0b, predicted %0b",
                         want.column_index, got.frame_last, want.frame_last));
    endtask

    function int pending();
      return expected_columns.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  cpf_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  cpf_pkg::out_t out_data;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  column_scoreboard_t sb = new();
  int items_sent = 0;
  int settings_used = 0;
  // When set, neither side idles between items.
  bit steady = 1'b0;

  column_projection_function u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: a random hold-off before each item is taken, none when steady.
  initial begin
    int hold;
    out_ready = 1'b0;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 7);
      repeat (hold) @(negedge clk) out_ready <= 1'b0;
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d column results outstanding", sb.pending());
    $display("Mismatches found");
    $finish;
  end

  task automatic send_pixel(logic [cpf_pkg::PIXEL_W-1:0] pixel, logic cend, logic fend);
    cpf_pkg::in_t item;
    int gap;
    item.pixel = pixel;
    item.column_end = cend;
    item.frame_end = fend;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(item);
    items_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    hold_input();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_register(logic reg_sel, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.note_register(reg_sel, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A pixel without a column end gives nothing to wait for, so allow it to finish too.
  task automatic configure(int unsigned alpha, int unsigned height);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    program_register(cpf_pkg::REG_ALPHA, alpha);
    program_register(cpf_pkg::REG_HEIGHT, height);
    settings_used++;
  endtask

  task automatic send_column(int len, pattern_t mode, bit frame_tail, bit end_flag);
    int base;
    logic [cpf_pkg::PIXEL_W-1:0] p;
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (mode)
        NOISE:   p = 8'($urandom_range(0, 255));
        BRIGHT:  p = 8'hFF;
        DARK:    p = 8'h00;
        BAND:    p = 8'(base + $urandom_range(0, 15));
        default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_pixel(p, (i == len - 1) && end_flag, (i == len - 1) && frame_tail);
    end
  endtask

  // Mostly whole columns; some short, some overlong, and a few with the end flag dropped.
  task automatic send_frame(int columns, int rows);
    int len, pick;
    bit tail, end_flag;
    for (int c = 0; c < columns; c++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = rows;
      else if (pick == 7) len = $urandom_range(1, rows);
      else len = rows + $urandom_range(1, 6);
      tail = (c == columns - 1);
      end_flag = tail ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) != 0);
      send_column(len, pattern_t'($urandom_range(0, 4)), tail, end_flag);
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    int unsigned alpha_set[8] = '{32768, 0, 65536, 131071, 1, 50000, 65535, 20000};
    int unsigned height_set[8] = '{64, 5, 12, 30, 0, 100, 3, 64};
    int unsigned alpha, height;
    int rows, phase, phase_start;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a one-pixel column, a frame end on its own, then both flags together.
    send_pixel(8'hFF, 1'b1, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b1);
    send_pixel(8'hFF, 1'b1, 1'b1);
    // Pure mean with height one; the second column is too long and saturates.
    configure(0, 1);
    send_pixel(8'hFF, 1'b1, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b1, 1'b0);
    send_pixel(8'h00, 1'b1, 1'b1);
    // Pure variance; an overlong column drives the spread below zero.
    configure(65536, 1);
    send_pixel(8'd100, 1'b0, 1'b0);
    send_pixel(8'd100, 1'b1, 1'b0);
    send_pixel(8'hFF, 1'b1, 1'b1);
    // Weight above one and a height of zero.
    configure(131071, 0);
    send_pixel(8'h80, 1'b1, 1'b0);
    send_pixel(8'h07, 1'b0, 1'b0);
    send_pixel(8'hFA, 1'b0, 1'b1);
    // Height above the largest supported.
    configure(65535, 127);
    send_pixel(8'hFF, 1'b0, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b0);
    send_pixel(8'h00, 1'b1, 1'b1);
    configure(1, 2);
    send_pixel(8'h55, 1'b0, 1'b0);
    send_pixel(8'hAA, 1'b1, 1'b0);
    send_pixel(8'hF0, 1'b0, 1'b0);
    send_pixel(8'h0F, 1'b1, 1'b1);

    // One long frame of single-pixel columns so that the column index wraps.
    configure($urandom_range(0, 65536), 1);
    for (int i = 0; i < LONG_FRAME; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      send_pixel(8'($urandom_range(0, 255)), 1'b1, i == LONG_FRAME - 1);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 8) begin
        alpha = alpha_set[phase];
        height = height_set[phase];
      end else begin
        alpha = $urandom_range(0, 131071);
        height = $urandom_range(0, 127);
      end
      configure(alpha, height);
      rows = (height == 0) ? 1 : (height > cpf_pkg::MAX_HEIGHT) ? cpf_pkg::MAX_HEIGHT : height;
      phase_start = items_sent;
      // A bright column past full height wraps both sums.
      if (rows == cpf_pkg::MAX_HEIGHT && phase == 0)
        send_column(rows + 4, BRIGHT, 1'b0, 1'b1);
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        steady = ($urandom_range(0, 4) == 0);
        send_frame($urandom_range(1, 10), rows);
      end
      phase++;
    end

    steady = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d pixel items, %0d column results and %0d register settings.",
             items_sent, sb.results_checked, settings_used);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
